[rtl/ffdsc_pkg.sv]
`timescale 1ns / 1ps

package ffdsc_pkg;

   // Frame markers
   localparam logic [7:0] START_MARK = 8'h2A;   // '*'
   localparam logic [7:0] END_MARK   = 8'h23;   // '#'

   // Start mark, two sum bytes and end mark
   localparam int unsigned FRAME_OVERHEAD = 4;

   // Width of the window fill count (frames up to 127 bytes)
   localparam int unsigned FILL_WIDTH = 7;

   // State of the payload buffer as seen by the top level
   typedef struct packed {
      logic valid;   // a payload byte sits at the head
      logic last;    // the head byte closes the frame
   } out_status_type;

endpackage

[rtl/ffdsc_out_buffer.sv]
`timescale 1ns / 1ps

module ffdsc_out_buffer #(
   parameter int unsigned PAYLOAD_LENGTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic [7:0]                 load_bytes [PAYLOAD_LENGTH],
   input  logic                       pop,
   output ffdsc_pkg::out_status_type  status,
   output logic [7:0]                 head_byte
);

   localparam int unsigned CW = $clog2(PAYLOAD_LENGTH + 1);

   logic [7:0]    bytes_ff [PAYLOAD_LENGTH];
   logic [7:0]    bytes_in [PAYLOAD_LENGTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // Load must only come into an empty buffer; this block does not enforce it. Pop shifts the line toward the head.
   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      if (load) begin
         bytes_in = load_bytes;
         count_in = CW'(PAYLOAD_LENGTH);
      end else if (pop && (count_ff != '0)) begin
         for (int i = 0; i < PAYLOAD_LENGTH - 1; i++) begin
            bytes_in[i] = bytes_ff[i + 1];
         end
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign status.valid = (count_ff != '0);
   assign status.last  = (count_ff == CW'(1));
   assign head_byte    = bytes_ff[0];

endmodule

[rtl/fixed_frame_deframer_sum_check_unit.sv]
`timescale 1ns / 1ps

// Fixed-length frame deframer with a 16-bit sum check. Every req_ transaction
// carries one received byte; the block keeps a sliding window of the last
// PACKET_LENGTH bytes. A frame is '*', PACKET_LENGTH-4 payload bytes, a
// big-endian 16-bit sum of the payload (high byte first) and '#'. When the
// window is full and holds such a frame with a matching sum, the payload bytes
// leave on the rsp_ channel in order, the final one with rsp_tlast set, and the
// window empties; otherwise nothing is sent and the window keeps sliding.
// Rate: one byte is taken per cycle while req_tready is high. The closing '#'
// is registered into the window, the payload then into the frame buffer, and
// its bytes leave one per cycle while rsp_tready is high. The payload goes out
// from a single frame buffer, so req_tready drops only while that buffer still
// drains and the window is within one byte of full; with rsp_tready held high
// that never happens and the sustained rate is one byte per cycle. The payload
// sum is a running value: one add per filling byte, add and subtract per slide.
module fixed_frame_deframer_sum_check_unit #(
   parameter int unsigned PACKET_LENGTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   // Received byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   // Validated payload stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic       rsp_tlast    // last_byte
);

   localparam int unsigned PAYLOAD_LENGTH = PACKET_LENGTH - ffdsc_pkg::FRAME_OVERHEAD;
   localparam int unsigned FW             = ffdsc_pkg::FILL_WIDTH;

   // Window storage: oldest byte at index 0. No reset, entries are read only
   // after being written since the window last emptied.
   logic [7:0]    window_ff [PACKET_LENGTH];
   logic [7:0]    window_in [PACKET_LENGTH];
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;
   logic [FW-1:0] fill_eff;
   // Running sum of the payload positions 1 .. PACKET_LENGTH-4 held in the window
   logic [15:0]   sum_ff;
   logic [15:0]   sum_in;
   logic [15:0]   sum_eff;

   logic          frame_hit;
   logic          window_full;
   logic          accept;
   logic [7:0]    payload [PAYLOAD_LENGTH];

   ffdsc_pkg::out_status_type out_status;

   // Check the registered window. A hit empties the window in this very cycle,
   // so a byte taken now lands at the front of a fresh window.
   assign frame_hit = (fill_ff == FW'(PACKET_LENGTH))
                   && (window_ff[PACKET_LENGTH - 1] == ffdsc_pkg::END_MARK)
                   && (window_ff[0] == ffdsc_pkg::START_MARK)
                   && (sum_ff == {window_ff[PACKET_LENGTH - 3], window_ff[PACKET_LENGTH - 2]});

   assign fill_eff    = frame_hit ? '0 : fill_ff;
   assign sum_eff     = frame_hit ? '0 : sum_ff;
   assign window_full = (fill_eff == FW'(PACKET_LENGTH));

   // Hold off the byte that could complete a frame while the buffer still drains.
   assign req_tready = (fill_eff < FW'(PACKET_LENGTH - 1)) || !out_status.valid;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_eff;
      sum_in    = sum_eff;
      if (accept) begin
         if (window_full) begin
            // Slide: drop the oldest byte, append the new one at the end.
            for (int i = 0; i < PACKET_LENGTH - 1; i++) begin
               window_in[i] = window_ff[i + 1];
            end
            window_in[PACKET_LENGTH - 1] = req_tdata;
            sum_in = sum_eff - {8'h00, window_ff[1]} + {8'h00, window_ff[PACKET_LENGTH - 3]};
         end else begin
            // Fill: append at the current count.
            for (int i = 0; i < PACKET_LENGTH; i++) begin
               if (fill_eff == FW'(i)) begin
                  window_in[i] = req_tdata;
               end
            end
            fill_in = fill_eff + FW'(1);
            if (fill_eff == '0) begin
               sum_in = '0;
            end else if (fill_eff <= FW'(PAYLOAD_LENGTH)) begin
               sum_in = sum_eff + {8'h00, req_tdata};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      if (reset) begin
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   always_comb begin
      for (int i = 0; i < PAYLOAD_LENGTH; i++) begin
         payload[i] = window_ff[i + 1];
      end
   end

   // Payload buffer: loaded on a hit, drained one transaction per cycle while rsp_tready is high.
   ffdsc_out_buffer #(
      .PAYLOAD_LENGTH (PAYLOAD_LENGTH)
   ) u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (frame_hit),
      .load_bytes (payload),
      .pop        (rsp_tready),
      .status     (out_status),
      .head_byte  (rsp_tdata)
   );

   assign rsp_tvalid = out_status.valid;
   assign rsp_tlast  = out_status.last;

endmodule

[rtl/ffdsc_checker.sv]
`timescale 1ns / 1ps

module ffdsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("rsp payload changed while stalled");

   // A frame starts only after an accepted end mark has passed the window register and then the payload buffer.
   a_frame_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && (req_tdata == ffdsc_pkg::END_MARK), 2))
      else $error("frame output without a preceding end mark");

   // Inside a frame the payload runs on without a gap until the last byte.
   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("frame payload broken off before its last byte");

   // Input stalls only while payload is still waiting to leave.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with an empty payload buffer");

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind fixed_frame_deframer_sum_check_unit ffdsc_checker u_ffdsc_checker (.*);
